@@ rtl/bhmg3d_pkg.sv @@
// ----------------------------------------------------------------------------
// bhmg3d_pkg: shared types and constants of the block Hankel gather core
// Port field widths, register reset values, op codes, register indexes and
// the controller states.
// ----------------------------------------------------------------------------
package bhmg3d_pkg;

  // parameter defaults
  localparam int CAL_DIM_MAX_DEF    = 32;
  localparam int KERNEL_DIM_MAX_DEF = 8;
  localparam int COILS_MAX_DEF      = 8;
  localparam int SAMPLE_BITS_DEF    = 32;

  // field widths fixed by the port definition
  localparam int FIELD_W     = 32;
  localparam int ROW_W       = 15;
  localparam int COL_W       = 12;
  localparam int DEST_W      = 26;
  localparam int ROWCNT_W    = 16;
  localparam int COLCNT_W    = 13;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 152;
  localparam int OP_W        = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int KREG_W     = 4;
  localparam int CREG_W     = 6;

  localparam logic [KREG_W-1:0] KERNEL_RST = 4'd5;
  localparam logic [CREG_W-1:0] CALIB_RST  = 6'd24;
  localparam logic [KREG_W-1:0] COILS_RST  = 4'd8;

  // cycles for the size products to follow a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_FETCH   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_X = 3'd0,
    CFG_KERNEL_Y = 3'd1,
    CFG_KERNEL_Z = 3'd2,
    CFG_CALIB_X  = 3'd3,
    CFG_CALIB_Y  = 3'd4,
    CFG_CALIB_Z  = 3'd5,
    CFG_COILS    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR1,
    ST_ADDR2,
    ST_ADDR3,
    ST_READ,
    ST_ENTRY,
    ST_STATUS
  } state_e;

endpackage

@@ rtl/bhmg3d_ram.sv @@
// ----------------------------------------------------------------------------
// bhmg3d_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bhmg3d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/block_hankel_matrix_gather_3d_core.sv @@
// ----------------------------------------------------------------------------
// block_hankel_matrix_gather_3d_core: multi-coil 3D block Hankel gather
// Stores a complex calibration volume and streams its sliding-window matrix.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: tuser carries the op (load, fetch, restart, no-op), tdata
//   the sample words. A load writes the next sample of the volume (x fastest,
//   then y, z, coil); loads past the volume are dropped. A restart clears
//   the load pointer and the matrix walk.
//   A fetch produces exactly one master transaction: the next matrix entry
//   (row, col, column-major dest index, sample words, tlast on the final
//   entry) or, with tuser status high, no entry (walk finished or a kernel
//   side larger than its volume side). Sizes ride along in every result.
// Input flow
//   Loads, restarts and no-ops are taken back to back. A fetch holds the
//   input while three multiply-add steps build the store address, one step
//   reads the sample RAM and one commits the result. A status-only fetch
//   skips to its commit. The address chain and RAM read set fetch length.
// Reset and configuration
//   After reset and after each register write tready stays low while the
//   size products settle; a write to a known register index also restarts
//   the walk. Store contents are undefined until loaded.
// Backpressure
//   The result sits in an output register; while it waits, loads are still
//   taken and the next fetch runs up to its commit, then holds.
// ----------------------------------------------------------------------------
module block_hankel_matrix_gather_3d_core
  import bhmg3d_pkg::*;
#(
  parameter int CAL_DIM_MAX    = CAL_DIM_MAX_DEF,
  parameter int KERNEL_DIM_MAX = KERNEL_DIM_MAX_DEF,
  parameter int COILS_MAX      = COILS_MAX_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // slave stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_real, sample_imag
  input  logic [OP_W-1:0]        s_axis_tuser,   // op
  // master stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // row, col, dest_index,
                                                 // entry_real, entry_imag,
                                                 // row_count, column_count
  output logic [0:0]             m_axis_tuser,   // status
  output logic                   m_axis_tlast    // last
);

  // store geometry
  localparam int DEPTH = CAL_DIM_MAX * CAL_DIM_MAX * CAL_DIM_MAX * COILS_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  // counter and size widths
  localparam int CW    = $clog2(CAL_DIM_MAX);
  localparam int CDW   = $clog2(CAL_DIM_MAX + 1);
  localparam int KOW   = (KERNEL_DIM_MAX > 1) ? $clog2(KERNEL_DIM_MAX) : 1;
  localparam int KDW   = $clog2(KERNEL_DIM_MAX + 1);
  localparam int COW   = (COILS_MAX > 1) ? $clog2(COILS_MAX) : 1;
  localparam int CNW   = $clog2(COILS_MAX + 1);
  localparam int MMW   = 2 * CDW;
  localparam int RW    = 3 * CDW;
  localparam int KKW   = 2 * KDW;
  localparam int CKW   = KDW + CNW;
  localparam int COLSW = 3 * KDW + CNW;
  localparam int CCW   = CDW + CNW;
  localparam int MW    = 2 * SAMPLE_BITS;

  // ---------------------------------------------------------------- config
  logic [KREG_W-1:0] kernel_x_q, kernel_y_q, kernel_z_q, coil_count_q;
  logic [CREG_W-1:0] calib_x_q, calib_y_q, calib_z_q;
  logic              cfg_known;
  logic [1:0]        settle_q;

  always_comb begin
    unique case (cfg_idx_e'(cfg_idx_i))
      CFG_KERNEL_X, CFG_KERNEL_Y, CFG_KERNEL_Z,
      CFG_CALIB_X, CFG_CALIB_Y, CFG_CALIB_Z, CFG_COILS: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_x_q   <= KERNEL_RST;
      kernel_y_q   <= KERNEL_RST;
      kernel_z_q   <= KERNEL_RST;
      calib_x_q    <= CALIB_RST;
      calib_y_q    <= CALIB_RST;
      calib_z_q    <= CALIB_RST;
      coil_count_q <= COILS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL_X: kernel_x_q   <= cfg_wdata_i[KREG_W-1:0];
        CFG_KERNEL_Y: kernel_y_q   <= cfg_wdata_i[KREG_W-1:0];
        CFG_KERNEL_Z: kernel_z_q   <= cfg_wdata_i[KREG_W-1:0];
        CFG_CALIB_X:  calib_x_q    <= cfg_wdata_i;
        CFG_CALIB_Y:  calib_y_q    <= cfg_wdata_i;
        CFG_CALIB_Z:  calib_z_q    <= cfg_wdata_i;
        CFG_COILS:    coil_count_q <= cfg_wdata_i[KREG_W-1:0];
        default: ;
      endcase
    end
  end

  // input blocked until the size products below are valid again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_CYCLES;
    end else if (cfg_we_i) begin
      settle_q <= SETTLE_CYCLES;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [6:0] clamp_dim(input logic [5:0] v, input logic [6:0] maxv);
    logic [6:0] r;
    if (v == 6'd0) begin
      r = 7'd1;
    end else if ({1'b0, v} > maxv) begin
      r = maxv;
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  logic [6:0] ks0, ks1, ks2, cs0, cs1, cs2, coils, m0, m1, m2;
  logic       bad;

  always_comb begin
    ks0   = clamp_dim(6'(kernel_x_q), 7'(KERNEL_DIM_MAX));
    ks1   = clamp_dim(6'(kernel_y_q), 7'(KERNEL_DIM_MAX));
    ks2   = clamp_dim(6'(kernel_z_q), 7'(KERNEL_DIM_MAX));
    cs0   = clamp_dim(calib_x_q, 7'(CAL_DIM_MAX));
    cs1   = clamp_dim(calib_y_q, 7'(CAL_DIM_MAX));
    cs2   = clamp_dim(calib_z_q, 7'(CAL_DIM_MAX));
    coils = clamp_dim(6'(coil_count_q), 7'(COILS_MAX));
    bad   = (ks0 > cs0) || (ks1 > cs1) || (ks2 > cs2);
    // window counts; meaningless when bad, never used then
    m0    = cs0 - ks0 + 7'd1;
    m1    = cs1 - ks1 + 7'd1;
    m2    = cs2 - ks2 + 7'd1;
  end

  // two-stage size products: rows, columns and volume
  logic [MMW-1:0]   mm01_q, cc01_q;
  logic [CDW-1:0]   m2_q;
  logic [KKW-1:0]   kk01_q;
  logic [CKW-1:0]   ckk_q;
  logic [CCW-1:0]   cc2c_q;
  logic [RW-1:0]    rows_q;
  logic [COLSW-1:0] cols_q;
  logic [PW-1:0]    vol_q;

  always_ff @(posedge clk_i) begin
    mm01_q <= MMW'(CDW'(m0)) * MMW'(CDW'(m1));
    m2_q   <= CDW'(m2);
    kk01_q <= KKW'(KDW'(ks0)) * KKW'(KDW'(ks1));
    ckk_q  <= CKW'(CNW'(coils)) * CKW'(KDW'(ks2));
    cc01_q <= MMW'(CDW'(cs0)) * MMW'(CDW'(cs1));
    cc2c_q <= CCW'(CDW'(cs2)) * CCW'(CNW'(coils));
    rows_q <= RW'(mm01_q) * RW'(m2_q);
    cols_q <= COLSW'(kk01_q) * COLSW'(ckk_q);
    vol_q  <= PW'(cc01_q * cc2c_q);
  end

  // ------------------------------------------------------------ handshakes
  state_e state_q, state_d;
  logic   in_fire, slot_free, restart, load_en, ram_re;
  logic   entry_commit, status_commit;
  op_e    op;

  logic [PW-1:0]     ptr_q;
  logic              done_q;
  logic [CW-1:0]     wx_q, wy_q, wz_q;
  logic [KOW-1:0]    kx_q, ky_q, kz_q;
  logic [COW-1:0]    coil_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [DEST_W-1:0] dest_q;
  logic              out_valid_q;

  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE) && (settle_q == 2'd0);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign restart       = (cfg_we_i && cfg_known) || (in_fire && op == OP_RESTART);
  assign load_en       = in_fire && (op == OP_LOAD) && (ptr_q < vol_q);

  // fetch sequencer
  always_comb begin
    state_d       = state_q;
    ram_re        = 1'b0;
    entry_commit  = 1'b0;
    status_commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && op == OP_FETCH) begin
          state_d = (bad || done_q) ? ST_STATUS : ST_ADDR1;
        end
      end
      ST_ADDR1: state_d = ST_ADDR2;
      ST_ADDR2: state_d = ST_ADDR3;
      ST_ADDR3: state_d = ST_READ;
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_ENTRY;
      end
      ST_ENTRY: begin
        if (slot_free) begin
          entry_commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          status_commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------- store address
  // addr = px + cs0*(py + cs1*(pz + cs2*coil)), one multiply-add per cycle
  logic [AW-1:0] addr_q;
  logic [AW-1:0] px, py, pz;

  assign px = AW'(wx_q) + AW'(kx_q);
  assign py = AW'(wy_q) + AW'(ky_q);
  assign pz = AW'(wz_q) + AW'(kz_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_ADDR1: addr_q <= pz + AW'(cs2) * AW'(coil_q);
      ST_ADDR2: addr_q <= py + AW'(cs1) * addr_q;
      ST_ADDR3: addr_q <= px + AW'(cs0) * addr_q;
      default:  addr_q <= addr_q;
    endcase
  end

  // Loads only land in IDLE and reads only run inside a fetch, so the two
  // ports never touch the same entry in one cycle.
  logic [MW-1:0] rdata;

  bhmg3d_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_en),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i ({s_axis_tdata[FIELD_W +: SAMPLE_BITS], s_axis_tdata[0 +: SAMPLE_BITS]}),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // ------------------------------------------------------------ matrix walk
  // kernel x, y, z, coil inside window x, y, z; row and col count linearly
  logic k0w, k1w, k2w, cw, w0w, w1w, w2w;

  always_comb begin
    k0w = (7'(kx_q) + 7'd1) == ks0;
    k1w = k0w && ((7'(ky_q) + 7'd1) == ks1);
    k2w = k1w && ((7'(kz_q) + 7'd1) == ks2);
    cw  = k2w && ((7'(coil_q) + 7'd1) == coils);
    w0w = cw  && ((7'(wx_q) + 7'd1) == m0);
    w1w = w0w && ((7'(wy_q) + 7'd1) == m1);
    w2w = w1w && ((7'(wz_q) + 7'd1) == m2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      done_q <= 1'b0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
      kx_q   <= '0;
      ky_q   <= '0;
      kz_q   <= '0;
      coil_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      dest_q <= '0;
    end else if (restart) begin
      ptr_q  <= '0;
      done_q <= 1'b0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
      kx_q   <= '0;
      ky_q   <= '0;
      kz_q   <= '0;
      coil_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      dest_q <= '0;
    end else begin
      if (load_en) begin
        ptr_q <= ptr_q + PW'(1);
      end
      if (entry_commit) begin
        kx_q <= k0w ? '0 : kx_q + KOW'(1);
        if (k0w) begin
          ky_q <= k1w ? '0 : ky_q + KOW'(1);
        end
        if (k1w) begin
          kz_q <= k2w ? '0 : kz_q + KOW'(1);
        end
        if (k2w) begin
          coil_q <= cw ? '0 : coil_q + COW'(1);
        end
        if (cw) begin
          wx_q <= w0w ? '0 : wx_q + CW'(1);
        end
        if (w0w) begin
          wy_q <= w1w ? '0 : wy_q + CW'(1);
        end
        if (w1w) begin
          wz_q <= w2w ? '0 : wz_q + CW'(1);
        end
        if (w2w) begin
          done_q <= 1'b1;
          row_q  <= '0;
          col_q  <= '0;
          dest_q <= '0;
        end else if (cw) begin
          // next window: col back to zero, dest is the new row
          row_q  <= row_q + ROW_W'(1);
          col_q  <= '0;
          dest_q <= DEST_W'(row_q + ROW_W'(1));
        end else begin
          col_q  <= col_q + COL_W'(1);
          dest_q <= dest_q + DEST_W'(rows_q);
        end
      end
    end
  end

  // ---------------------------------------------------------- result slot
  logic                out_status_q, out_last_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [COL_W-1:0]    out_col_q;
  logic [DEST_W-1:0]   out_dest_q;
  logic [FIELD_W-1:0]  out_real_q, out_imag_q;
  logic [ROWCNT_W-1:0] out_rowcnt_q;
  logic [COLCNT_W-1:0] out_colcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (entry_commit || status_commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_commit || status_commit) begin
      out_status_q <= status_commit;
      out_rowcnt_q <= bad ? '0 : ROWCNT_W'(rows_q);
      out_colcnt_q <= COLCNT_W'(cols_q);
      if (entry_commit) begin
        out_row_q  <= row_q;
        out_col_q  <= col_q;
        out_dest_q <= dest_q;
        out_real_q <= FIELD_W'(rdata[SAMPLE_BITS-1:0]);
        out_imag_q <= FIELD_W'(rdata[MW-1:SAMPLE_BITS]);
        out_last_q <= w2w;
      end else begin
        out_row_q  <= '0;
        out_col_q  <= '0;
        out_dest_q <= '0;
        out_real_q <= '0;
        out_imag_q <= '0;
        out_last_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {
    (OUT_TDATA_W - (ROW_W + COL_W + DEST_W + 2 * FIELD_W + ROWCNT_W + COLCNT_W))'(0),
    out_colcnt_q, out_rowcnt_q, out_imag_q, out_real_q,
    out_dest_q, out_col_q, out_row_q
  };

endmodule

@@ test/tb_block_hankel_matrix_gather_3d_core.sv @@
// ----------------------------------------------------------------------------
// tb_block_hankel_matrix_gather_3d_core: self-checking bench of the gather core
// Loads small calibration volumes, walks their block Hankel matrices with
// fetch transactions and checks every result against an in-bench predictor
// of the store, the load pointer and the window/kernel/coil walk. Directed
// cases cover the reset sizes, the end of the walk, restart, no-op, loads
// past the volume, out-of-range and ignored register writes and an oversize
// kernel; random phases reconfigure the sizes under three stall patterns.
// ----------------------------------------------------------------------------
module tb_block_hankel_matrix_gather_3d_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bhmg3d_pkg::*;

  localparam realtime     CLK_HALF       = 6.0;
  localparam int unsigned STORE_DEPTH    = CAL_DIM_MAX_DEF * CAL_DIM_MAX_DEF *
                                           CAL_DIM_MAX_DEF * COILS_MAX_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_ITEMS   = 600;   // per stall pattern
  localparam int unsigned MAX_PRODUCT    = 150;   // bound on volume and matrix entries per random geometry

  // register index with no register behind it; writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // result word, row in the low bits, as packed on the master tdata
  typedef struct packed {
    logic [COLCNT_W-1:0] column_count;
    logic [ROWCNT_W-1:0] row_count;
    logic [FIELD_W-1:0]  entry_im;
    logic [FIELD_W-1:0]  entry_re;
    logic [DEST_W-1:0]   dest_index;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } gather_word_t;

  localparam int GATHER_W = $bits(gather_word_t);

  typedef struct packed {
    logic         status;
    logic         last;
    gather_word_t word;
  } gather_result_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = OP_NOP;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  block_hankel_matrix_gather_3d_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // sample_real, sample_imag
    .s_axis_tuser  (s_axis_tuser),   // op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // row, col, dest_index, entry_real,
                                     // entry_imag, row_count, column_count
    .m_axis_tuser  (m_axis_tuser),   // status
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: registers, sample store and the matrix walk
  // --------------------------------------------------------------------------
  int unsigned kernel_reg [3] = '{KERNEL_RST, KERNEL_RST, KERNEL_RST};
  int unsigned calib_reg  [3] = '{CALIB_RST, CALIB_RST, CALIB_RST};
  int unsigned coil_reg       = COILS_RST;

  bit [63:0]   sample_mem     [STORE_DEPTH];
  bit          sample_written [STORE_DEPTH];  // guards against reading unloaded entries
  int unsigned load_ptr = 0;
  int unsigned win_pos [3] = '{0, 0, 0};
  int unsigned k_off   [3] = '{0, 0, 0};
  int unsigned coil_pos  = 0;
  bit          walk_done = 1'b0;

  // effective sizes, refreshed before each use
  int unsigned ks_eff [3];
  int unsigned cs_eff [3];
  int unsigned win_cnt[3];
  int unsigned coils_eff, row_total, col_total;
  bit          oversize;

  gather_result_t expected_results[$];

  // run bookkeeping
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned n_entries     = 0;
  int unsigned n_status      = 0;
  int unsigned n_loads       = 0;
  int unsigned n_cfg_writes  = 0;
  int unsigned quiet_cycles  = 0;
  gather_result_t got_result, want_result;

  function automatic int unsigned effective_side(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void refresh_geometry();
    oversize = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ks_eff[a] = effective_side(kernel_reg[a], KERNEL_DIM_MAX_DEF);
      cs_eff[a] = effective_side(calib_reg[a], CAL_DIM_MAX_DEF);
      if (ks_eff[a] > cs_eff[a]) begin
        oversize   = 1'b1;
        win_cnt[a] = 0;
      end else begin
        win_cnt[a] = cs_eff[a] - ks_eff[a] + 1;
      end
    end
    coils_eff = effective_side(coil_reg, COILS_MAX_DEF);
    row_total = oversize ? 0 : win_cnt[0] * win_cnt[1] * win_cnt[2];
    col_total = coils_eff * ks_eff[0] * ks_eff[1] * ks_eff[2];
  endfunction

  function automatic void restart_walk();
    load_ptr  = 0;
    win_pos   = '{0, 0, 0};
    k_off     = '{0, 0, 0};
    coil_pos  = 0;
    walk_done = 1'b0;
  endfunction

  // store address of the sample the next fetch gathers
  function automatic int unsigned gather_addr();
    return (win_pos[0] + k_off[0]) + cs_eff[0] * ((win_pos[1] + k_off[1]) +
           cs_eff[1] * ((win_pos[2] + k_off[2]) + cs_eff[2] * coil_pos));
  endfunction

  // a fetch may only be sent when it reads a loaded sample or gives a status
  function automatic bit fetch_is_safe();
    refresh_geometry();
    if (oversize || walk_done) return 1'b1;
    return sample_written[gather_addr()];
  endfunction

  // kernel x, y, z, then coil, then window x, y, z; returns the last mark
  function automatic bit advance_walk();
    k_off[0]++;
    if (k_off[0] < ks_eff[0]) return 1'b0;
    k_off[0] = 0;
    k_off[1]++;
    if (k_off[1] < ks_eff[1]) return 1'b0;
    k_off[1] = 0;
    k_off[2]++;
    if (k_off[2] < ks_eff[2]) return 1'b0;
    k_off[2] = 0;
    coil_pos++;
    if (coil_pos < coils_eff) return 1'b0;
    coil_pos = 0;
    win_pos[0]++;
    if (win_pos[0] < win_cnt[0]) return 1'b0;
    win_pos[0] = 0;
    win_pos[1]++;
    if (win_pos[1] < win_cnt[1]) return 1'b0;
    win_pos[1] = 0;
    win_pos[2]++;
    if (win_pos[2] < win_cnt[2]) return 1'b0;
    win_pos[2] = 0;
    walk_done  = 1'b1;
    return 1'b1;
  endfunction

  // update the predictor for one accepted slave transaction
  function automatic void apply_item(op_e op, logic [FIELD_W-1:0] re, logic [FIELD_W-1:0] im);
    gather_result_t want;
    int unsigned    row_idx, col_idx, dest;
    bit [63:0]      word;
    refresh_geometry();
    case (op)
      OP_RESTART: restart_walk();
      OP_LOAD: begin
        // loads past the volume are dropped, pointer stays put
        if (load_ptr < cs_eff[0] * cs_eff[1] * cs_eff[2] * coils_eff) begin
          sample_mem[load_ptr]     = {im, re};
          sample_written[load_ptr] = 1'b1;
          load_ptr++;
          n_loads++;
        end
      end
      OP_FETCH: begin
        want                   = '0;
        want.word.row_count    = row_total[ROWCNT_W-1:0];
        want.word.column_count = col_total[COLCNT_W-1:0];
        if (oversize || walk_done) begin
          want.status = 1'b1;
          n_status++;
        end else begin
          row_idx = win_pos[0] + win_cnt[0] * (win_pos[1] + win_cnt[1] * win_pos[2]);
          col_idx = k_off[0] + ks_eff[0] * (k_off[1] + ks_eff[1] *
                    (k_off[2] + ks_eff[2] * coil_pos));
          dest    = row_idx + row_total * col_idx;
          word    = sample_mem[gather_addr()];
          want.word.row        = row_idx[ROW_W-1:0];
          want.word.col        = col_idx[COL_W-1:0];
          want.word.dest_index = dest[DEST_W-1:0];
          want.word.entry_re   = word[31:0];
          want.word.entry_im   = word[63:32];
          want.last            = advance_walk();
          n_entries++;
        end
        expected_results.push_back(want);
      end
      default: ;  // no-op
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the scoreboard check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  function automatic string describe(gather_result_t r);
    return $sformatf("st=%0d last=%0d row=%0d col=%0d dest=%0d re=%h im=%h rows=%0d cols=%0d",
                     r.status, r.last, r.word.row, r.word.col, r.word.dest_index,
                     r.word.entry_re, r.word.entry_im, r.word.row_count,
                     r.word.column_count);
  endfunction

  // counts every mismatch, says whether this one still gets printed
  function automatic bit log_mismatch();
    mismatches++;
    return mismatches <= MAX_REPORTS;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result = {m_axis_tuser[0], m_axis_tlast, m_axis_tdata[GATHER_W-1:0]};
      if (expected_results.size() == 0) begin
        if (log_mismatch())
          $display("[%0t] result with nothing pending: %s", $time, describe(got_result));
      end else begin
        want_result = expected_results.pop_front();
        // pad bits above the packed fields must stay zero
        if (got_result !== want_result || m_axis_tdata[OUT_TDATA_W-1:GATHER_W] !== '0) begin
          if (log_mismatch()) begin
            $display("[%0t] gather result mismatch", $time);
            $display("  expected %s", describe(want_result));
            $display("  actual   %s pad=%h", describe(got_result),
                     m_axis_tdata[OUT_TDATA_W-1:GATHER_W]);
          end
        end
      end
    end
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // one slave transaction; tvalid stays high into the next item unless we idle
  task automatic send_item(input op_e op, input logic [FIELD_W-1:0] re,
                           input logic [FIELD_W-1:0] im);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {im, re};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_item(op, re, im);
  endtask

  // hold the sender until every pending result is back, then let the
  // last load or restart retire before touching the registers
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    bit known;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    known = 1'b1;
    case (idx)
      CFG_KERNEL_X: kernel_reg[0] = data[KREG_W-1:0];
      CFG_KERNEL_Y: kernel_reg[1] = data[KREG_W-1:0];
      CFG_KERNEL_Z: kernel_reg[2] = data[KREG_W-1:0];
      CFG_CALIB_X:  calib_reg[0]  = data[CREG_W-1:0];
      CFG_CALIB_Y:  calib_reg[1]  = data[CREG_W-1:0];
      CFG_CALIB_Z:  calib_reg[2]  = data[CREG_W-1:0];
      CFG_COILS:    coil_reg      = data[KREG_W-1:0];
      default:      known = 1'b0;
    endcase
    if (known) restart_walk();  // any real write restarts both sequences
    n_cfg_writes++;
  endtask

  // pick a register code for a side: 0 stands for 1, codes past the max clamp,
  // bits above a 4-bit register are dropped by the block
  function automatic logic [CFG_DATA_W-1:0] encode_side(int unsigned v, int unsigned maxv,
                                                        int unsigned width);
    int unsigned code;
    code = v;
    if (v == 1 && $urandom_range(1) == 1) code = 0;
    else if (v == maxv && $urandom_range(1) == 1) code = $urandom_range(maxv + 1, (1 << width) - 1);
    if (width < CFG_DATA_W) code = code | ($urandom_range(3) << width);
    return code[CFG_DATA_W-1:0];
  endfunction

  task automatic program_sizes(input int unsigned kx, ky, kz, cx, cy, cz, co);
    if ($urandom_range(3) == 0) cfg_write(CFG_UNUSED, $urandom_range(63));
    cfg_write(CFG_KERNEL_X, encode_side(kx, KERNEL_DIM_MAX_DEF, KREG_W));
    cfg_write(CFG_KERNEL_Y, encode_side(ky, KERNEL_DIM_MAX_DEF, KREG_W));
    cfg_write(CFG_KERNEL_Z, encode_side(kz, KERNEL_DIM_MAX_DEF, KREG_W));
    cfg_write(CFG_CALIB_X,  encode_side(cx, CAL_DIM_MAX_DEF, CREG_W));
    cfg_write(CFG_CALIB_Y,  encode_side(cy, CAL_DIM_MAX_DEF, CREG_W));
    cfg_write(CFG_CALIB_Z,  encode_side(cz, CAL_DIM_MAX_DEF, CREG_W));
    cfg_write(CFG_COILS,    encode_side(co, COILS_MAX_DEF, KREG_W));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset sizes (24^3 volume, 5^3 kernel, 8 coils): only the first two
  // samples are loaded, and only those two are gathered
  task automatic test_default_sizes();
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOAD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_FETCH, $urandom, $urandom);
    send_item(OP_FETCH, $urandom, $urandom);
  endtask

  // 2x1x1 volume, unit kernel: end of walk, finished status, load past the
  // volume, no-op, restart, ignored register index
  task automatic test_walk_end_and_ops();
    drain_results();
    cfg_write(CFG_KERNEL_X, 6'd0);    // acts as 1
    cfg_write(CFG_KERNEL_Y, 6'd1);
    cfg_write(CFG_KERNEL_Z, 6'h30);   // upper bits dropped, acts as 1
    cfg_write(CFG_CALIB_X,  6'd2);
    cfg_write(CFG_CALIB_Y,  6'd0);
    cfg_write(CFG_CALIB_Z,  6'd1);
    cfg_write(CFG_COILS,    6'd0);
    send_item(OP_LOAD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOAD, 32'hA5A5_A5A5, 32'h5A5A_5A5A);  // past the volume, dropped
    send_item(OP_FETCH, $urandom, $urandom);
    send_item(OP_NOP, $urandom, $urandom);
    send_item(OP_FETCH, $urandom, $urandom);           // carries tlast
    send_item(OP_FETCH, $urandom, $urandom);           // walk finished
    drain_results();
    cfg_write(CFG_UNUSED, 6'h3F);                      // must not restart the walk
    send_item(OP_FETCH, $urandom, $urandom);
    send_item(OP_RESTART, $urandom, $urandom);
    send_item(OP_FETCH, $urandom, $urandom);
    send_item(OP_LOAD, 32'h1234_5678, 32'h9ABC_DEF0);  // overwrites sample 0
    send_item(OP_FETCH, $urandom, $urandom);
  endtask

  // kernel sides past the volume: status only, zero rows, clamped codes
  task automatic test_kernel_oversize();
    drain_results();
    cfg_write(CFG_CALIB_X,  6'd63);   // acts as 32
    cfg_write(CFG_CALIB_Y,  6'd1);
    cfg_write(CFG_CALIB_Z,  6'd1);
    cfg_write(CFG_KERNEL_X, 6'd15);   // acts as 8
    cfg_write(CFG_KERNEL_Y, 6'd9);    // acts as 8, larger than the y side
    cfg_write(CFG_KERNEL_Z, 6'd1);
    cfg_write(CFG_COILS,    6'd15);   // acts as 8
    send_item(OP_FETCH, $urandom, $urandom);
    send_item(OP_LOAD, $urandom, $urandom);
    send_item(OP_FETCH, $urandom, $urandom);
  endtask

  // largest side and kernel on one axis, then all coils; full walks
  task automatic test_extreme_sizes();
    drain_results();
    program_sizes(KERNEL_DIM_MAX_DEF, 1, 1, CAL_DIM_MAX_DEF, 1, 1, 1);
    repeat (CAL_DIM_MAX_DEF) send_item(OP_LOAD, $urandom, $urandom);
    repeat (row_total * col_total + 1) send_item(OP_FETCH, $urandom, $urandom);
    drain_results();
    program_sizes(1, 2, 1, 2, 2, 1, COILS_MAX_DEF);
    repeat (4 * COILS_MAX_DEF) send_item(OP_LOAD, $urandom, $urandom);
    repeat (row_total * col_total + 1) send_item(OP_FETCH, $urandom, $urandom);
  endtask

  // random small geometries: fill the volume, walk the matrix, with some
  // no-ops, restarts, stray loads, partial fills and oversize kernels mixed in
  task automatic test_random_volumes(input int unsigned n_items);
    int unsigned sent, kx, ky, kz, cx, cy, cz, co, vol, rows, cols, fill, steps, pick;
    bit          bad;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      do begin
        cx = $urandom_range(1, 5);
        cy = $urandom_range(1, 5);
        cz = $urandom_range(1, 5);
        co = $urandom_range(1, 3);
        if ($urandom_range(9) == 0) begin
          kx = $urandom_range(1, KERNEL_DIM_MAX_DEF);
          ky = $urandom_range(1, KERNEL_DIM_MAX_DEF);
          kz = $urandom_range(1, KERNEL_DIM_MAX_DEF);
        end else begin
          kx = $urandom_range(1, cx);
          ky = $urandom_range(1, cy);
          kz = $urandom_range(1, cz);
        end
        bad  = (kx > cx) || (ky > cy) || (kz > cz);
        rows = bad ? 0 : (cx - kx + 1) * (cy - ky + 1) * (cz - kz + 1);
        cols = co * kx * ky * kz;
        vol  = cx * cy * cz * co;
      end while (vol > MAX_PRODUCT || rows * cols > MAX_PRODUCT);
      program_sizes(kx, ky, kz, cx, cy, cz, co);

      fill = ($urandom_range(6) == 0) ? $urandom_range(1, vol) : vol + $urandom_range(0, 2);
      repeat (fill) send_item(OP_LOAD, $urandom, $urandom);
      sent += fill;

      steps = bad ? $urandom_range(1, 3) : rows * cols + $urandom_range(0, 3);
      repeat (steps) begin
        pick = $urandom_range(99);
        if (pick < 3)       send_item(OP_NOP, $urandom, $urandom);
        else if (pick < 5)  send_item(OP_RESTART, $urandom, $urandom);
        else if (pick < 9)  send_item(OP_LOAD, $urandom, $urandom);
        else if (fetch_is_safe()) send_item(OP_FETCH, $urandom, $urandom);
        else                send_item(OP_LOAD, $urandom, $urandom);  // finish a partial fill
      end
      sent += steps;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles 30 %, receiver 49 %
    src_idle_pct  = 30;
    sink_idle_pct = 49;
    test_default_sizes();
    test_walk_end_and_ops();
    test_kernel_oversize();
    test_extreme_sizes();
    test_random_volumes(RANDOM_ITEMS);

    // roles swapped
    src_idle_pct  = 49;
    sink_idle_pct = 30;
    test_random_volumes(RANDOM_ITEMS);

    // full rate both ways
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_volumes(RANDOM_ITEMS);

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("covered %0d gathered entries and %0d status-only results", n_entries, n_status);
    $display("over %0d stored samples and %0d register writes", n_loads, n_cfg_writes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
